FILE: rtl/xxh_pkg.sv
// xxh_pkg: shared constants, sequencer state type and helper functions for
// the xxhash64 stream hasher. No dependencies.
package xxh_pkg;

   // xxhash64 primes
   localparam logic [63:0] XXH_P1 = 64'd11400714785074694791;
   localparam logic [63:0] XXH_P2 = 64'd14029467366897019727;
   localparam logic [63:0] XXH_P3 = 64'd1609587929392839161;
   localparam logic [63:0] XXH_P4 = 64'd9650029242287828579;
   localparam logic [63:0] XXH_P5 = 64'd2870177450012600261;

   // half-word width used by the partial-product multiplier
   localparam int XXH_HALF = 32;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LR_W1,
      ST_LR_W2,
      ST_CONV,
      ST_CONV_SUM,
      ST_MERGE,
      ST_MG_W1,
      ST_MG_W2,
      ST_MG_W3,
      ST_LEN,
      ST_PEND,
      ST_PD_W1,
      ST_PD_W2,
      ST_PD_W3,
      ST_WORD4,
      ST_W4_W1,
      ST_W4_W2,
      ST_BYTE,
      ST_BY_W1,
      ST_BY_W2,
      ST_AV,
      ST_AV_W1,
      ST_AV_W2,
      ST_EMIT
   } xxh_state_type;

   // rotate left by a constant amount (1..63)
   function automatic logic [63:0] xxh_rotl(input logic [63:0] x, input logic [5:0] r);
      return (x << r) | (x >> (7'd64 - {1'b0, r}));
   endfunction

   // lane rotation used when the four lanes converge
   function automatic logic [63:0] xxh_conv_rot(input logic [63:0] x, input logic [1:0] i);
      logic [63:0] res;
      case (i)
         2'd0: res = xxh_rotl(x, 6'd1);
         2'd1: res = xxh_rotl(x, 6'd7);
         2'd2: res = xxh_rotl(x, 6'd12);
         2'd3: res = xxh_rotl(x, 6'd18);
         default: res = x;
      endcase
      return res;
   endfunction

endpackage

FILE: rtl/xxhash64_stream_hasher_core.sv
// xxhash64_stream_hasher_core: streaming xxhash64 over 64-bit little-endian words.
// Depends on xxh_pkg and xxh_mul.
//
// Send a message as requests of one 64-bit word each, first byte in bits 7:0,
// with tlast on the final word; the byte count (0..8, above 8 counts as 8) is
// used only on that final word, and one 64-bit hash comes back per message.
// The seed is sampled when the first word of a message is taken. All
// arithmetic runs through one 64-bit multiplier that uses a single 32x32
// multiplier over partial products, each multiply begun by a registered start.
// A non-final word that does not complete a 32-byte stripe is buffered; a word
// that completes a stripe runs the four lane rounds, each a multiply by prime 2
// and then one by prime 1. The final word adds the converge and lane merges
// (only if a stripe was seen), the length, each leftover word, a 4-byte chunk,
// the single bytes and the avalanche. The block takes a new request only when
// the sequencer is idle; a finished hash waits in the output register while
// the next message is accepted.
module xxhash64_stream_hasher_core
   import xxh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [63:0] data_word, [67:64] byte_count, [71:68] zero
   input  logic        req_tlast,   // last
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] hash_value
   // seed register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data
);

   xxh_state_type state_ff, state_in;

   logic [63:0] lane_ff [4];
   logic [63:0] lane_in [4];
   logic [63:0] pend_ff [3];
   logic [63:0] pend_in [3];
   logic [1:0]  pcnt_ff, pcnt_in;
   logic [63:0] total_ff, total_in;
   logic        stripe_ff, stripe_in;
   logic        inmsg_ff, inmsg_in;
   logic [63:0] word_ff, word_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic [2:0]  nrem_ff, nrem_in;
   logic [1:0]  idx_ff, idx_in;
   logic [2:0]  bidx_ff, bidx_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] m_a_ff, m_a_in;
   logic [63:0] m_b_ff, m_b_in;
   logic        m_start_ff, m_start_in;
   logic [63:0] seed_ff, seed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic        mul_done;
   logic [63:0] mul_prod;
   logic        req_take;
   logic [3:0]  nsat;
   logic        full_word;
   logic        emit_ok;
   logic [63:0] lane_next_src;
   logic [63:0] pend_sel;
   logic [63:0] mix_x;

   // shared multiplier
   xxh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (m_start_ff),
      .op_a    (m_a_ff),
      .op_b    (m_b_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // handshake helpers
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign emit_ok    = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // byte count saturation and full-word test
   assign nsat      = (cnt_ff > 4'd8) ? 4'd8 : cnt_ff;
   assign full_word = !last_ff || (nsat == 4'd8);

   // word feeding the next lane round, and the leftover word being folded
   always_comb begin
      case (idx_ff)
         2'd0: lane_next_src = pend_ff[1];
         2'd1: lane_next_src = pend_ff[2];
         default: lane_next_src = word_ff;
      endcase
      case (idx_ff)
         2'd0: pend_sel = pend_ff[0];
         2'd1: pend_sel = pend_ff[1];
         default: pend_sel = pend_ff[2];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (full_word && (pcnt_ff == 2'd3)) begin
               state_in = ST_LR_W1;
            end else if (last_ff) begin
               state_in = ST_CONV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LR_W1: begin
            if (mul_done) begin
               state_in = ST_LR_W2;
            end
         end
         ST_LR_W2: begin
            if (mul_done) begin
               if (idx_ff != 2'd3) begin
                  state_in = ST_LR_W1;
               end else if (last_ff) begin
                  state_in = ST_CONV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CONV: begin
            state_in = stripe_ff ? ST_CONV_SUM : ST_LEN;
         end
         ST_CONV_SUM: begin
            if (idx_ff == 2'd3) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: state_in = ST_MG_W1;
         ST_MG_W1: begin
            if (mul_done) begin
               state_in = ST_MG_W2;
            end
         end
         ST_MG_W2: begin
            if (mul_done) begin
               state_in = ST_MG_W3;
            end
         end
         ST_MG_W3: begin
            if (mul_done) begin
               state_in = (idx_ff == 2'd3) ? ST_LEN : ST_MERGE;
            end
         end
         ST_LEN: state_in = ST_PEND;
         ST_PEND: begin
            state_in = (idx_ff < pcnt_ff) ? ST_PD_W1 : ST_WORD4;
         end
         ST_PD_W1: begin
            if (mul_done) begin
               state_in = ST_PD_W2;
            end
         end
         ST_PD_W2: begin
            if (mul_done) begin
               state_in = ST_PD_W3;
            end
         end
         ST_PD_W3: begin
            if (mul_done) begin
               state_in = ST_PEND;
            end
         end
         ST_WORD4: begin
            state_in = nrem_ff[2] ? ST_W4_W1 : ST_BYTE;
         end
         ST_W4_W1: begin
            if (mul_done) begin
               state_in = ST_W4_W2;
            end
         end
         ST_W4_W2: begin
            if (mul_done) begin
               state_in = ST_BYTE;
            end
         end
         ST_BYTE: begin
            state_in = (bidx_ff < nrem_ff) ? ST_BY_W1 : ST_AV;
         end
         ST_BY_W1: begin
            if (mul_done) begin
               state_in = ST_BY_W2;
            end
         end
         ST_BY_W2: begin
            if (mul_done) begin
               state_in = ST_BYTE;
            end
         end
         ST_AV: state_in = ST_AV_W1;
         ST_AV_W1: begin
            if (mul_done) begin
               state_in = ST_AV_W2;
            end
         end
         ST_AV_W2: begin
            if (mul_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      lane_in      = lane_ff;
      pend_in      = pend_ff;
      pcnt_in      = pcnt_ff;
      total_in     = total_ff;
      stripe_in    = stripe_ff;
      inmsg_in     = inmsg_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      nrem_in      = nrem_ff;
      idx_in       = idx_ff;
      bidx_in      = bidx_ff;
      h_in         = h_ff;
      m_a_in       = m_a_ff;
      m_b_in       = m_b_ff;
      m_start_in   = 1'b0;
      seed_in      = seed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mix_x        = '0;

      // seed register write
      if (csr_valid && csr_ready) begin
         seed_in = csr_data;
      end

      // response handed over
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // take a request, open a message if none is open
         ST_IDLE: begin
            if (req_take) begin
               word_in = req_tdata[63:0];
               cnt_in  = req_tdata[67:64];
               last_in = req_tlast;
               if (!inmsg_ff) begin
                  lane_in[0] = seed_ff + XXH_P1 + XXH_P2;
                  lane_in[1] = seed_ff + XXH_P2;
                  lane_in[2] = seed_ff;
                  lane_in[3] = seed_ff - XXH_P1;
                  pcnt_in    = 2'd0;
                  total_in   = '0;
                  stripe_in  = 1'b0;
                  inmsg_in   = 1'b1;
               end
            end
         end
         // buffer the word or start a stripe
         ST_DECODE: begin
            idx_in = 2'd0;
            if (full_word) begin
               nrem_in  = 3'd0;
               total_in = total_ff + 64'd8;
               if (pcnt_ff == 2'd3) begin
                  m_a_in     = pend_ff[0];
                  m_b_in     = XXH_P2;
                  m_start_in = 1'b1;
               end else begin
                  pend_in[pcnt_ff] = word_ff;
                  pcnt_in          = pcnt_ff + 2'd1;
               end
            end else begin
               nrem_in = nsat[2:0];
            end
         end
         // lane round: add, rotate, multiply
         ST_LR_W1: begin
            if (mul_done) begin
               m_a_in     = xxh_rotl(lane_ff[idx_ff] + mul_prod, 6'd31);
               m_b_in     = XXH_P1;
               m_start_in = 1'b1;
            end
         end
         ST_LR_W2: begin
            if (mul_done) begin
               lane_in[idx_ff] = mul_prod;
               if (idx_ff == 2'd3) begin
                  stripe_in = 1'b1;
                  pcnt_in   = 2'd0;
                  idx_in    = 2'd0;
               end else begin
                  idx_in     = idx_ff + 2'd1;
                  m_a_in     = lane_next_src;
                  m_b_in     = XXH_P2;
                  m_start_in = 1'b1;
               end
            end
         end
         // converge lanes or start from seed plus prime 5
         ST_CONV: begin
            if (stripe_ff) begin
               h_in   = xxh_conv_rot(lane_ff[0], 2'd0);
               idx_in = 2'd1;
            end else begin
               h_in = lane_ff[2] + XXH_P5;
            end
         end
         ST_CONV_SUM: begin
            h_in   = h_ff + xxh_conv_rot(lane_ff[idx_ff], idx_ff);
            idx_in = idx_ff + 2'd1;
         end
         // merge one lane into the hash
         ST_MERGE: begin
            m_a_in     = lane_ff[idx_ff];
            m_b_in     = XXH_P2;
            m_start_in = 1'b1;
         end
         ST_MG_W1: begin
            if (mul_done) begin
               m_a_in     = xxh_rotl(mul_prod, 6'd31);
               m_b_in     = XXH_P1;
               m_start_in = 1'b1;
            end
         end
         ST_MG_W2: begin
            if (mul_done) begin
               m_a_in     = h_ff ^ mul_prod;
               m_b_in     = XXH_P1;
               m_start_in = 1'b1;
            end
         end
         ST_MG_W3: begin
            if (mul_done) begin
               h_in   = mul_prod + XXH_P4;
               idx_in = idx_ff + 2'd1;
            end
         end
         // add message length
         ST_LEN: begin
            h_in   = h_ff + total_ff + {61'h0, nrem_ff};
            idx_in = 2'd0;
         end
         // fold leftover whole words
         ST_PEND: begin
            if (idx_ff < pcnt_ff) begin
               m_a_in     = pend_sel;
               m_b_in     = XXH_P2;
               m_start_in = 1'b1;
            end
         end
         ST_PD_W1: begin
            if (mul_done) begin
               m_a_in     = xxh_rotl(mul_prod, 6'd31);
               m_b_in     = XXH_P1;
               m_start_in = 1'b1;
            end
         end
         ST_PD_W2: begin
            if (mul_done) begin
               m_a_in     = xxh_rotl(h_ff ^ mul_prod, 6'd27);
               m_b_in     = XXH_P1;
               m_start_in = 1'b1;
            end
         end
         ST_PD_W3: begin
            if (mul_done) begin
               h_in   = mul_prod + XXH_P4;
               idx_in = idx_ff + 2'd1;
            end
         end
         // fold a 4-byte chunk
         ST_WORD4: begin
            if (nrem_ff[2]) begin
               m_a_in     = {32'h0, word_ff[31:0]};
               m_b_in     = XXH_P1;
               m_start_in = 1'b1;
               bidx_in    = 3'd4;
            end else begin
               bidx_in = 3'd0;
            end
         end
         ST_W4_W1: begin
            if (mul_done) begin
               m_a_in     = xxh_rotl(h_ff ^ mul_prod, 6'd23);
               m_b_in     = XXH_P2;
               m_start_in = 1'b1;
            end
         end
         ST_W4_W2: begin
            if (mul_done) begin
               h_in = mul_prod + XXH_P3;
            end
         end
         // fold single bytes
         ST_BYTE: begin
            if (bidx_ff < nrem_ff) begin
               m_a_in     = {56'h0, word_ff[bidx_ff*8 +: 8]};
               m_b_in     = XXH_P5;
               m_start_in = 1'b1;
            end
         end
         ST_BY_W1: begin
            if (mul_done) begin
               m_a_in     = xxh_rotl(h_ff ^ mul_prod, 6'd11);
               m_b_in     = XXH_P1;
               m_start_in = 1'b1;
            end
         end
         ST_BY_W2: begin
            if (mul_done) begin
               h_in    = mul_prod;
               bidx_in = bidx_ff + 3'd1;
            end
         end
         // avalanche
         ST_AV: begin
            m_a_in     = h_ff ^ (h_ff >> 33);
            m_b_in     = XXH_P2;
            m_start_in = 1'b1;
         end
         ST_AV_W1: begin
            if (mul_done) begin
               mix_x      = mul_prod ^ (mul_prod >> 29);
               m_a_in     = mix_x;
               m_b_in     = XXH_P3;
               m_start_in = 1'b1;
            end
         end
         ST_AV_W2: begin
            if (mul_done) begin
               h_in     = mul_prod ^ (mul_prod >> 32);
               inmsg_in = 1'b0;
               pcnt_in  = 2'd0;
            end
         end
         // hand the hash to the output register
         ST_EMIT: begin
            if (emit_ok) begin
               rsp_data_in  = h_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            m_start_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcnt_ff      <= 2'd0;
         total_ff     <= '0;
         stripe_ff    <= 1'b0;
         inmsg_ff     <= 1'b0;
         m_start_ff   <= 1'b0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         bidx_ff      <= 3'd0;
      end else begin
         state_ff     <= state_in;
         pcnt_ff      <= pcnt_in;
         total_ff     <= total_in;
         stripe_ff    <= stripe_in;
         inmsg_ff     <= inmsg_in;
         m_start_ff   <= m_start_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         bidx_ff      <= bidx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lane_ff     <= lane_in;
      pend_ff     <= pend_in;
      word_ff     <= word_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      nrem_ff     <= nrem_in;
      h_ff        <= h_in;
      m_a_ff      <= m_a_in;
      m_b_ff      <= m_b_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/xxh_mul.sv
// xxh_mul: 64x64 multiplier keeping the low 64 product bits, built from one
// shared 32x32 multiplier over three partial products. Uses xxh_pkg.
module xxh_mul
   import xxh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [2:0]  step_ff, step_in;
   logic [63:0] lo_ff, lo_in;
   logic [31:0] cr_ff, cr_in;
   logic [63:0] prod_ff, prod_in;
   logic        done_ff, done_in;

   logic [XXH_HALF-1:0] mx;
   logic [XXH_HALF-1:0] my;
   logic [63:0]         mp;

   // operand select for the shared 32x32 multiplier
   always_comb begin
      case (step_ff)
         3'd1: begin
            mx = a_ff[XXH_HALF-1:0];
            my = b_ff[XXH_HALF-1:0];
         end
         3'd2: begin
            mx = a_ff[63:XXH_HALF];
            my = b_ff[XXH_HALF-1:0];
         end
         3'd3: begin
            mx = a_ff[XXH_HALF-1:0];
            my = b_ff[63:XXH_HALF];
         end
         default: begin
            mx = '0;
            my = '0;
         end
      endcase
      mp = mx * my;
   end

   // partial-product sequence: low, cross high*low, cross low*high, sum
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      step_in = step_ff;
      lo_in   = lo_ff;
      cr_in   = cr_ff;
      prod_in = prod_ff;
      done_in = 1'b0;
      case (step_ff)
         3'd0: begin
            if (start) begin
               a_in    = op_a;
               b_in    = op_b;
               step_in = 3'd1;
            end
         end
         3'd1: begin
            lo_in   = mp;
            step_in = 3'd2;
         end
         3'd2: begin
            cr_in   = mp[31:0];
            step_in = 3'd3;
         end
         3'd3: begin
            cr_in   = cr_ff + mp[31:0];
            step_in = 3'd4;
         end
         3'd4: begin
            prod_in = lo_ff + {cr_ff, 32'h0};
            done_in = 1'b1;
            step_in = 3'd0;
         end
         default: begin
            step_in = 3'd0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   // operand and partial-product registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      lo_ff   <= lo_in;
      cr_ff   <= cr_in;
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

FILE: tb/xxhash64_stream_hasher_core_tb.sv
// xxhash64_stream_hasher_core_tb: self-checking bench for the streaming xxhash64 core.
// Predicts every hash in the bench itself and checks each response in order.
// Depends on rtl/xxhash64_stream_hasher_core.sv, rtl/xxh_mul.sv and their package.
module xxhash64_stream_hasher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
   localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
   localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
   localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
   localparam logic [63:0] PRIME5 = 64'd2870177450012600261;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam int RANDOM_WORDS = 1450;

   // kinds of queued stimulus
   typedef enum logic [1:0] {SEQ_WORD, SEQ_SEED, SEQ_PAUSE} seq_kind_type;

   typedef struct {
      seq_kind_type kind;
      logic [63:0]  value;
      logic [3:0]   nbytes;
      logic         fin;
      int           gap;
   } seq_entry_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // [63:0] data_word, [67:64] byte_count, [71:68] zero
   logic        req_tlast;   // last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [63:0] hash_value
   logic        csr_valid;
   logic        csr_ready;
   logic [63:0] csr_data;

   xxhash64_stream_hasher_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // stimulus and expected hashes
   seq_entry_type stim_q[$];
   logic [63:0]   expected_hashes[$];

   // predictor state
   logic [63:0] seed_reg = '0;
   logic [63:0] lane[4] = '{default: '0};
   logic [63:0] held[3] = '{default: '0};
   int          held_cnt = 0;
   logic [63:0] byte_len = '0;
   logic        striped = 1'b0;
   logic        msg_open = 1'b0;

   // bookkeeping
   bit          req_took = 1'b0;
   bit          csr_took = 1'b0;
   int          hold_left = 0;
   int          words_queued = 0;
   int          words_sent = 0;
   int          words_hashed = 0;
   int          hashes_checked = 0;
   int          seed_writes = 0;
   int          mismatches = 0;
   int          stall_cycles = 0;
   bit          calm;

   assign calm = (words_sent >= 600) && (words_sent < 850);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
      logic [127:0] d;
      d = {x, x} << r;
      return d[127:64];
   endfunction

   function automatic logic [63:0] lane_mix(input logic [63:0] acc, input logic [63:0] w);
      logic [63:0] a;
      a = acc + w * PRIME2;
      return rotl64(a, 31) * PRIME1;
   endfunction

   // buffer a whole word, or consume a full stripe with three held words
   task automatic word_absorb(input logic [63:0] w);
      if (held_cnt >= 3) begin
         for (int k = 0; k < 3; k++) lane[k] = lane_mix(lane[k], held[k]);
         lane[3] = lane_mix(lane[3], w);
         striped = 1'b1;
         held_cnt = 0;
      end else begin
         held[held_cnt] = w;
         held_cnt++;
      end
      byte_len += 64'd8;
   endtask

   // track one accepted request word, queue a hash on the last word
   task automatic hash_track(input logic [63:0] w, input logic [3:0] cnt, input logic fin);
      logic [63:0] h;
      int n;
      int k;
      if (!msg_open) begin
         lane[0] = seed_reg + PRIME1 + PRIME2;
         lane[1] = seed_reg + PRIME2;
         lane[2] = seed_reg;
         lane[3] = seed_reg - PRIME1;
         held_cnt = 0;
         byte_len = '0;
         striped = 1'b0;
         msg_open = 1'b1;
      end
      if (!fin) begin
         word_absorb(w);
      end else begin
         n = (cnt > 4'd8) ? 8 : int'(cnt);
         if (n == 8) begin
            word_absorb(w);
            n = 0;
         end
         // converge lanes or take the short-message start
         if (striped) begin
            h = rotl64(lane[0], 1) + rotl64(lane[1], 7) + rotl64(lane[2], 12) +
                rotl64(lane[3], 18);
            for (k = 0; k < 4; k++) begin
               h ^= lane_mix('0, lane[k]);
               h = h * PRIME1 + PRIME4;
            end
         end else begin
            h = lane[2] + PRIME5;
         end
         h += byte_len + 64'(n);
         // leftover words, 4-byte chunk, single bytes
         for (k = 0; k < held_cnt; k++) begin
            h ^= lane_mix('0, held[k]);
            h = rotl64(h, 27) * PRIME1 + PRIME4;
         end
         k = 0;
         if (n >= 4) begin
            h ^= {32'b0, w[31:0]} * PRIME1;
            h = rotl64(h, 23) * PRIME2 + PRIME3;
            k = 4;
         end
         for (; k < n; k++) begin
            h ^= {56'b0, w[8*k +: 8]} * PRIME5;
            h = rotl64(h, 11) * PRIME1;
         end
         // avalanche
         h ^= h >> 33;
         h *= PRIME2;
         h ^= h >> 29;
         h *= PRIME3;
         h ^= h >> 32;
         expected_hashes.push_back(h);
         msg_open = 1'b0;
         held_cnt = 0;
      end
   endtask

   // driver: presents queued requests and seed writes on the falling edge
   always @(negedge clock) begin : drive
      seq_entry_type head;
      logic          v_next;
      logic          c_next;
      if (!reset) begin
         v_next = req_tvalid && !req_took;
         c_next = csr_valid && !csr_took;
         if (hold_left > 0) begin
            hold_left--;
         end else if (!v_next && !c_next && stim_q.size() > 0) begin
            head = stim_q[0];
            case (head.kind)
               SEQ_WORD: begin
                  if (calm || $urandom_range(0, 99) >= 8) begin
                     void'(stim_q.pop_front());
                     req_tdata <= {4'b0, head.nbytes, head.value};
                     req_tlast <= head.fin;
                     v_next = 1'b1;
                     words_sent++;
                  end
               end
               SEQ_SEED: begin
                  void'(stim_q.pop_front());
                  csr_data <= head.value;
                  c_next = 1'b1;
               end
               SEQ_PAUSE: begin
                  if (expected_hashes.size() == 0) begin
                     void'(stim_q.pop_front());
                     hold_left = head.gap;
                  end
               end
               default: void'(stim_q.pop_front());
            endcase
         end
         req_tvalid <= v_next;
         csr_valid <= c_next;
         rsp_tready <= calm || ($urandom_range(0, 99) >= 8);
      end
   end

   // monitor: handshakes, prediction, hash check and watchdog on the rising edge
   always @(posedge clock) begin : watch
      logic [63:0] want;
      bit          rsp_took;
      req_took = !reset && req_tvalid && req_tready;
      csr_took = !reset && csr_valid && csr_ready;
      rsp_took = !reset && rsp_tvalid && rsp_tready;
      if (csr_took) begin
         seed_reg = csr_data;
         seed_writes++;
      end
      if (req_took) begin
         hash_track(req_tdata[63:0], req_tdata[67:64], req_tlast);
         words_hashed++;
      end
      if (rsp_took) begin
         if (expected_hashes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected hash %h", rsp_tdata);
         end else begin
            want = expected_hashes.pop_front();
            hashes_checked++;
            if (rsp_tdata !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("hash mismatch: expected %h got %h", want, rsp_tdata);
            end
         end
      end
      // watchdog on cycles with no handshake at all
      if (reset || req_took || csr_took || rsp_took) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without progress", stall_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [63:0] rnd64();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic push_word(input logic [63:0] v, input logic [3:0] n, input logic fin);
      seq_entry_type e;
      e = '{kind: SEQ_WORD, value: v, nbytes: n, fin: fin, gap: 0};
      stim_q.push_back(e);
      words_queued++;
   endtask

   // settle, then write the seed while the core is idle
   task automatic push_seed_write(input logic [63:0] v);
      seq_entry_type e;
      e = '{kind: SEQ_PAUSE, value: '0, nbytes: '0, fin: 1'b0, gap: SETTLE_CYCLES};
      stim_q.push_back(e);
      e = '{kind: SEQ_SEED, value: v, nbytes: '0, fin: 1'b0, gap: 0};
      stim_q.push_back(e);
   endtask

   // message of random length; sometimes a seed write lands mid-message
   task automatic push_random_message();
      int nwords;
      int pick;
      int split;
      logic [3:0] n;
      pick = $urandom_range(0, 99);
      if (pick < 70) nwords = $urandom_range(1, 8);
      else if (pick < 95) nwords = $urandom_range(9, 20);
      else nwords = $urandom_range(21, 40);
      split = ($urandom_range(0, 19) == 0) ? $urandom_range(1, nwords) : 0;
      for (int k = 1; k <= nwords; k++) begin
         if (k == split && k > 1) push_seed_write(rnd64());
         if (k < nwords) begin
            n = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
            push_word(rnd64(), n, 1'b0);
         end else begin
            n = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
            push_word(rnd64(), n, 1'b1);
         end
      end
   endtask

   // stimulus, reset and end of run
   initial begin : stimulus
      int next_phase;
      int phase;
      logic [63:0] pick;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;

      // directed: empty message, short lengths 1, 3, 4 and 7, saturated count
      push_seed_write(64'd0);
      push_word(64'h0123_4567_89ab_cdef, 4'd0, 1'b1);
      push_word(64'hffff_ffff_ffff_ffff, 4'd1, 1'b1);
      push_word(64'h0000_0000_0000_0000, 4'd3, 1'b1);
      push_word(64'hdead_beef_cafe_f00d, 4'd4, 1'b1);
      push_word(64'h8000_0000_8000_0001, 4'd7, 1'b1);
      push_word(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
      // short count on a non-last word is treated as a full word
      push_word(64'h1111_2222_3333_4444, 4'd3, 1'b0);
      push_word(64'h5555_6666_7777_8888, 4'd5, 1'b1);
      // exactly one stripe, ending on a full last word
      push_seed_write('1);
      for (int k = 0; k < 3; k++) push_word('1, 4'd8, 1'b0);
      push_word('1, 4'd8, 1'b1);
      // stripe plus two leftover words, a 4-byte chunk and single bytes
      for (int k = 0; k < 6; k++) push_word(64'h0f0f_0f0f_0f0f_0f0f << k, 4'd8, 1'b0);
      push_word(64'ha5a5_a5a5_5a5a_5a5a, 4'd7, 1'b1);
      // seed written mid-message only applies to the next message
      push_word(64'h0000_0000_0000_0001, 4'd8, 1'b0);
      push_word(64'h8000_0000_0000_0000, 4'd8, 1'b0);
      push_seed_write(64'h8000_0000_0000_0000);
      push_word(64'h7fff_ffff_ffff_ffff, 4'd2, 1'b1);
      push_word(64'h0000_0000_0000_0000, 4'd6, 1'b1);

      // random part in phases with a new seed each time
      next_phase = words_queued;
      phase = 0;
      while (words_queued < RANDOM_WORDS + 25) begin
         if (words_queued >= next_phase) begin
            case (phase % 5)
               0: pick = '0;
               1: pick = '1;
               2: pick = 64'h8000_0000_0000_0000;
               3: pick = 64'd1;
               default: pick = {$urandom, $urandom};
            endcase
            push_seed_write(pick);
            phase++;
            next_phase += 150;
         end
         push_random_message();
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stim_q.size() > 0 || req_tvalid || csr_valid || hold_left > 0 ||
             expected_hashes.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatches += expected_hashes.size();

      $display("run covered %0d request words, %0d hashes checked, %0d seed writes",
               words_hashed, hashes_checked, seed_writes);
      $display("messages ranged from empty to 40 words, with idle and stall gaps on both sides");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
